FILE: src/tdpl_pkg.sv
// Package for the time-of-day period lookup.
// Field widths, operation codes, table entry and result types, minute-of-day conversion.
// No dependencies.
`default_nettype none
package tdpl_pkg;

	localparam int IDX_W    = 9;
	localparam int MIN_W    = 11;
	localparam int CNT_W    = 10;
	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;

	localparam logic [CNT_W-1:0] CNT_MAX         = '1;
	localparam logic [CNT_W-1:0] ENTRIES_RESET   = CNT_W'(24);
	localparam logic [MIN_W-1:0] MINUTES_PER_HOUR = MIN_W'(60);

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic [MIN_W-1:0] start_min;
		logic [MIN_W-1:0] end_min;
		logic             enabled;
	} entry_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] match_index;
		logic [CNT_W-1:0] enabled_count;
		logic             any_enabled;
		logic [IDX_W-1:0] first_enabled_index;
	} result_t;

	function automatic logic [MIN_W-1:0] to_minute(input logic [HOUR_W-1:0] hr,
			input logic [MINUTE_W-1:0] mn);
		logic [MIN_W-1:0] prod;
		prod = MIN_W'(hr) * MINUTES_PER_HOUR;
		return prod + MIN_W'(mn);
	endfunction

	function automatic logic covers(input logic [MIN_W-1:0] lo, input logic [MIN_W-1:0] hi,
			input logic [MIN_W-1:0] t);
		logic res;
		if (lo < hi) begin
			res = (t >= lo) && (t < hi);
		end else begin
			res = (t < hi) || (t >= lo);
		end
		return res;
	endfunction

endpackage
`default_nettype wire

FILE: src/time_of_day_period_lookup.sv
// Time-of-day period lookup: a write loads one table slot and gives no result.
// A query with N = min(entries_in_use, MAX_ENTRIES) scans table entries 0 to N-1 and keeps
// the block busy, stalling new requests, until its result is taken into the output register;
// the scan reads one entry per cycle through the single table memory read port. After reset
// entries_in_use is 24 and the table contents are undefined until written; there is no
// clearing pass. Depends on tdpl_pkg and tdpl_scan.
`default_nettype none
module time_of_day_period_lookup #(
	parameter int MAX_ENTRIES = 512
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_we,
	input  wire  [tdpl_pkg::CNT_W-1:0]        cfg_wdata,
	input  wire                               in_valid,
	output logic                              in_stall,
	input  wire                               op,
	input  wire  [tdpl_pkg::IDX_W-1:0]        entry_index,
	input  wire  [tdpl_pkg::MIN_W-1:0]        start_minute,
	input  wire  [tdpl_pkg::MIN_W-1:0]        end_minute,
	input  wire                               entry_enabled,
	input  wire  [tdpl_pkg::HOUR_W-1:0]       hour,
	input  wire  [tdpl_pkg::MINUTE_W-1:0]     minute,
	output logic                              out_valid,
	input  wire                               out_stall,
	output logic                              found,
	output logic [tdpl_pkg::IDX_W-1:0]        match_index,
	output logic [tdpl_pkg::CNT_W-1:0]        enabled_count,
	output logic                              any_enabled,
	output logic [tdpl_pkg::IDX_W-1:0]        first_enabled_index
);
	import tdpl_pkg::*;

	logic [CNT_W-1:0] entries_in_use_q;
	logic             in_accept;
	logic             busy;
	logic             res_valid;
	logic             res_take;
	result_t          res;
	result_t          out_q;
	logic             out_valid_q;
	entry_t           wr_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_in_use_q <= ENTRIES_RESET;
		end else if (cfg_we) begin
			entries_in_use_q <= cfg_wdata;
		end
	end

	assign in_stall  = busy;
	assign in_accept = in_valid && !busy;

	always_comb begin
		wr_entry.start_min = start_minute;
		wr_entry.end_min   = end_minute;
		wr_entry.enabled   = entry_enabled;
	end

	tdpl_scan #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (in_accept && (op == OP_WRITE)),
		.wr_index      (entry_index),
		.wr_entry      (wr_entry),
		.start         (in_accept && (op == OP_QUERY)),
		.query_min     (to_minute(hour, minute)),
		.entries_in_use(entries_in_use_q),
		.busy          (busy),
		.res_valid     (res_valid),
		.res_take      (res_take),
		.res           (res)
	);

	assign res_take = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid           = out_valid_q;
	assign found               = out_q.found;
	assign match_index         = out_q.match_index;
	assign enabled_count       = out_q.enabled_count;
	assign any_enabled         = out_q.any_enabled;
	assign first_enabled_index = out_q.first_enabled_index;

endmodule
`default_nettype wire

FILE: src/tdpl_scan.sv
// Period table memory and the sequencer that scans it for one query.
// Reads one entry per cycle with a registered read port and accumulates the result.
// Depends on tdpl_pkg.
`default_nettype none
module tdpl_scan #(
	parameter int MAX_ENTRIES = 512
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              wr_en,
	input  wire  [tdpl_pkg::IDX_W-1:0]       wr_index,
	input  wire  tdpl_pkg::entry_t           wr_entry,
	input  wire                              start,
	input  wire  [tdpl_pkg::MIN_W-1:0]       query_min,
	input  wire  [tdpl_pkg::CNT_W-1:0]       entries_in_use,
	output logic                             busy,
	output logic                             res_valid,
	input  wire                              res_take,
	output tdpl_pkg::result_t                res
);
	import tdpl_pkg::*;

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam logic [CW-1:0] MAX_N = CW'(MAX_ENTRIES);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	entry_t mem [MAX_ENTRIES];

	logic [1:0]       state_q;
	logic [CW-1:0]    iss_q;
	logic [CW-1:0]    n_q;
	logic [CW-1:0]    n_cap;
	logic [MIN_W-1:0] t_q;
	logic             vld_s1;
	logic [CW-1:0]    idx_s1;
	entry_t           rd_s1;
	logic             issue;
	logic [AW-1:0]    rd_addr;
	logic [AW-1:0]    wr_addr;
	logic [AW+IDX_W-1:0] wr_wide;
	logic             wr_ok;
	logic [CW+IDX_W-1:0] idx_wide;

	logic             found_q;
	logic [IDX_W-1:0] match_q;
	logic [CNT_W-1:0] count_q;
	logic             any_q;
	logic [IDX_W-1:0] first_q;

	assign wr_wide  = {{AW{1'b0}}, wr_index};
	assign wr_addr  = wr_wide[AW-1:0];
	assign wr_ok    = 32'(wr_index) < MAX_ENTRIES;
	assign n_cap    = (32'(entries_in_use) > MAX_ENTRIES) ? MAX_N : CW'(entries_in_use);
	assign issue    = (state_q == ST_SCAN) && (iss_q < n_q);
	assign rd_addr  = iss_q[AW-1:0];
	assign idx_wide = {{IDX_W{1'b0}}, idx_s1};

	always_ff @(posedge clk) begin
		if (wr_en && wr_ok) begin
			mem[wr_addr] <= wr_entry;
		end
		rd_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		idx_s1 <= iss_q;
		if (start && (state_q == ST_IDLE)) begin
			t_q <= query_min;
			n_q <= n_cap;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iss_q   <= '0;
			vld_s1  <= 1'b0;
			found_q <= 1'b0;
			match_q <= '0;
			count_q <= '0;
			any_q   <= 1'b0;
			first_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					vld_s1 <= 1'b0;
					if (start) begin
						state_q <= ST_SCAN;
						iss_q   <= '0;
						found_q <= 1'b0;
						match_q <= '0;
						count_q <= '0;
						any_q   <= 1'b0;
						first_q <= '0;
					end
				end
				ST_SCAN: begin
					vld_s1 <= issue;
					if (issue) begin
						iss_q <= iss_q + CW'(1);
					end
					if (vld_s1) begin
						if (!found_q && covers(rd_s1.start_min, rd_s1.end_min, t_q)) begin
							found_q <= 1'b1;
							match_q <= idx_wide[IDX_W-1:0];
						end
						if (rd_s1.enabled) begin
							if (!any_q) begin
								any_q   <= 1'b1;
								first_q <= idx_wide[IDX_W-1:0];
							end
							if (count_q != CNT_MAX) begin
								count_q <= count_q + CNT_W'(1);
							end
						end
					end
					if (!issue && !vld_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					vld_s1 <= 1'b0;
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					vld_s1  <= 1'b0;
				end
			endcase
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_DONE);

	always_comb begin
		res.found               = found_q;
		res.match_index         = match_q;
		res.enabled_count       = count_q;
		res.any_enabled         = any_q;
		res.first_enabled_index = first_q;
	end

endmodule
`default_nettype wire
